>>> design/psfm_pkg.sv
// psfm_pkg: shared types, codes and widths of the power stage fault monitor
// used by psfm_update and power_stage_fault_monitor_top; no dependencies
`timescale 1ns / 1ps

package psfm_pkg;

    localparam int AVG_W      = 15;
    localparam int SCALE_W    = 16;
    localparam int FLAG_W     = 6;
    localparam int VOLTS_W    = 16;
    localparam int CELS_W     = 8;
    localparam int OP_W       = 3;
    localparam int KIND_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int FRAC_W     = 15;

    // averaging lengths are powers of two: 64 and 2048
    localparam int BUS_AVG_SHIFT  = 6;
    localparam int TEMP_AVG_SHIFT = 11;

    localparam logic [CELS_W-1:0] TEMP_GAIN   = 8'd195;
    localparam logic [CELS_W-1:0] TEMP_OFFSET = 8'd14;

    localparam logic [AVG_W-1:0]   RST_OV_LIMIT   = 15'd26000;
    localparam logic [AVG_W-1:0]   RST_UV_LIMIT   = 15'd10000;
    localparam logic [AVG_W-1:0]   RST_OH_LIMIT   = 15'd9410;
    localparam logic [AVG_W-1:0]   RST_OH_RELEASE = 15'd7730;
    localparam logic [SCALE_W-1:0] RST_VOLT_SCALE = 16'd518;
    localparam logic [AVG_W-1:0]   RST_BUS_AVG    = 15'd18000;

    localparam int FLAG_OVERCURRENT = 0;
    localparam int FLAG_OVERHEAT    = 1;
    localparam int FLAG_UNDERVOLT   = 2;
    localparam int FLAG_SPEEDFB     = 3;
    localparam int FLAG_STARTUP     = 4;
    localparam int FLAG_OVERVOLT    = 5;

    typedef enum logic [OP_W-1:0] {
        OP_INIT       = 3'd0,
        OP_BUS_SAMPLE = 3'd1,
        OP_CHECK      = 3'd2,
        OP_CLEAR      = 3'd3,
        OP_SET_FAULT  = 3'd4
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OV_LIMIT   = 3'd0,
        REG_UV_LIMIT   = 3'd1,
        REG_OH_LIMIT   = 3'd2,
        REG_OH_RELEASE = 3'd3,
        REG_VOLT_SCALE = 3'd4
    } t_reg_idx;

    typedef enum logic [1:0] {
        BUS_OK    = 2'd0,
        BUS_OVER  = 2'd1,
        BUS_UNDER = 2'd2
    } t_bus_state;

    typedef struct packed {
        logic [AVG_W-1:0]   ov_limit;
        logic [AVG_W-1:0]   uv_limit;
        logic [AVG_W-1:0]   oh_limit;
        logic [AVG_W-1:0]   oh_release;
        logic [SCALE_W-1:0] volt_scale;
    } t_cfg;

    typedef struct packed {
        logic [AVG_W-1:0]  bus_avg;
        logic [AVG_W-1:0]  temp_avg;
        logic [FLAG_W-1:0] flags;
    } t_mon_state;

    typedef struct packed {
        t_op               op;
        logic [AVG_W-1:0]  bus_sample;
        logic [AVG_W-1:0]  temp_sample;
        logic              break_pin_high;
        logic [KIND_W-1:0] fault_kind;
    } t_item;

    // over voltage is tested first
    function automatic t_bus_state bus_class(input logic [AVG_W-1:0] avg,
                                             input logic [AVG_W-1:0] ov,
                                             input logic [AVG_W-1:0] uv);
        t_bus_state st;
        if (avg > ov) begin
            st = BUS_OVER;
        end else if (avg < uv) begin
            st = BUS_UNDER;
        end else begin
            st = BUS_OK;
        end
        return st;
    endfunction

endpackage

>>> design/psfm_update.sv
// psfm_update: next monitor state (averages and fault latch) for one word
// depends on psfm_pkg
`timescale 1ns / 1ps

module psfm_update (
    input  psfm_pkg::t_item      i_item,
    input  psfm_pkg::t_cfg       i_cfg,
    input  psfm_pkg::t_mon_state i_state,
    output psfm_pkg::t_mon_state o_state
);
    import psfm_pkg::*;

    localparam int BUS_ACC_W  = AVG_W + BUS_AVG_SHIFT + 1;
    localparam int TEMP_ACC_W = AVG_W + TEMP_AVG_SHIFT + 1;

    logic [BUS_ACC_W-1:0]  bus_acc;
    logic [TEMP_ACC_W-1:0] temp_acc;
    logic [AVG_W-1:0]      bus_step;
    logic [AVG_W-1:0]      temp_step;
    logic [AVG_W:0]        limit_sum;
    logic                  hot;
    t_bus_state            cur_class;

    // avg * (len - 1) + sample, then divide by len
    assign bus_acc = (BUS_ACC_W'(i_state.bus_avg) << BUS_AVG_SHIFT)
                     - BUS_ACC_W'(i_state.bus_avg) + BUS_ACC_W'(i_item.bus_sample);
    assign temp_acc = (TEMP_ACC_W'(i_state.temp_avg) << TEMP_AVG_SHIFT)
                      - TEMP_ACC_W'(i_state.temp_avg) + TEMP_ACC_W'(i_item.temp_sample);
    assign bus_step  = bus_acc[BUS_AVG_SHIFT +: AVG_W];
    assign temp_step = temp_acc[TEMP_AVG_SHIFT +: AVG_W];

    assign limit_sum = {1'b0, i_cfg.ov_limit} + {1'b0, i_cfg.uv_limit};

    // overheat with hysteresis
    assign hot = (temp_step >= i_cfg.oh_limit)
                 || ((temp_step >= i_cfg.oh_release) && i_state.flags[FLAG_OVERHEAT]);

    assign cur_class = bus_class(i_state.bus_avg, i_cfg.ov_limit, i_cfg.uv_limit);

    always_comb begin
        o_state = i_state;
        case (i_item.op)
            OP_INIT: begin
                o_state.bus_avg  = limit_sum[AVG_W:1];
                o_state.temp_avg = '0;
            end
            OP_BUS_SAMPLE: begin
                o_state.bus_avg = bus_step;
            end
            OP_CHECK: begin
                o_state.temp_avg = temp_step;
                if (hot) begin
                    o_state.flags[FLAG_OVERHEAT] = 1'b1;
                end
                if (cur_class == BUS_UNDER) begin
                    o_state.flags[FLAG_UNDERVOLT] = 1'b1;
                end
            end
            OP_CLEAR: begin
                if (i_state.flags[FLAG_OVERHEAT]) begin
                    o_state.temp_avg = temp_step;
                    if (!hot) begin
                        o_state.flags[FLAG_OVERHEAT] = 1'b0;
                    end
                end
                if (cur_class == BUS_OK) begin
                    o_state.flags[FLAG_OVERVOLT]  = 1'b0;
                    o_state.flags[FLAG_UNDERVOLT] = 1'b0;
                end
                if (i_item.break_pin_high) begin
                    o_state.flags[FLAG_OVERCURRENT] = 1'b0;
                end
                o_state.flags[FLAG_SPEEDFB] = 1'b0;
                o_state.flags[FLAG_STARTUP] = 1'b0;
            end
            OP_SET_FAULT: begin
                if (i_item.fault_kind < KIND_W'(FLAG_W)) begin
                    o_state.flags[i_item.fault_kind] = 1'b1;
                end
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

endmodule

>>> design/power_stage_fault_monitor_top.sv
// power_stage_fault_monitor_top: bus voltage and heatsink temperature fault monitor
// depends on psfm_pkg and psfm_update
//
//   channel  | ports                       | word
//   ---------+-----------------------------+-------------------------------------
//   input    | s_axis_tvalid/tready/tdata  | one operation with its samples
//            | s_axis_tuser                | and fault kind
//   result   | m_axis_tvalid/tready/tdata  | flags, all clear, bus state, volts,
//            |                             | celsius
//   config   | i_cfg_we/index/wdata        | one register write, no read-back
//
// three register stages: input word, monitor state update, scaling multiply
// one word per cycle sustained while the result channel is not stalled
// i_rst_n (synchronous, low) empties the pipe and loads register reset values
// a stalled result holds the stages behind it; s_axis_tready drops once all are full
`timescale 1ns / 1ps

module power_stage_fault_monitor_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [14:0] bus_sample, [29:15] temp_sample, [30] break_pin_high, [33:31] fault_kind
    input  logic [39:0] s_axis_tdata,
    // [2:0] operation
    input  logic [psfm_pkg::OP_W-1:0] s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [5:0] fault_flags, [6] all_clear, [8:7] bus_state, [24:9] bus_volts,
    // [32:25] temp_celsius
    output logic [39:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [psfm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [psfm_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import psfm_pkg::*;

    localparam int BUS_PROD_W  = AVG_W + SCALE_W;
    localparam int TEMP_PROD_W = AVG_W + CELS_W;

    t_cfg       r_cfg;
    t_mon_state r_state;
    t_mon_state n_state;

    logic  r_v1;
    t_item r_item;
    t_item n_item;

    logic             r_v2;
    logic [FLAG_W-1:0] r_s2_flags;
    logic [AVG_W-1:0] r_s2_bus;
    logic [AVG_W-1:0] r_s2_temp;

    logic               r_v3;
    logic [FLAG_W-1:0]  r_flags;
    logic               r_all_clear;
    t_bus_state         r_bus_state;
    logic [VOLTS_W-1:0] r_volts;
    logic [CELS_W-1:0]  r_celsius;

    logic w_ld3;
    logic w_ld2;
    logic w_acc;

    logic [BUS_PROD_W-1:0]  bus_prod;
    logic [TEMP_PROD_W-1:0] temp_prod;

    assign w_ld3 = !r_v3 || m_axis_tready;
    assign w_ld2 = !r_v2 || w_ld3;
    assign s_axis_tready = !r_v1 || w_ld2;
    assign w_acc = s_axis_tvalid && s_axis_tready;

    assign n_item.op             = t_op'(s_axis_tuser);
    assign n_item.bus_sample     = s_axis_tdata[14:0];
    assign n_item.temp_sample    = s_axis_tdata[29:15];
    assign n_item.break_pin_high = s_axis_tdata[30];
    assign n_item.fault_kind     = s_axis_tdata[33:31];

    psfm_update u_update (
        .i_item  (r_item),
        .i_cfg   (r_cfg),
        .i_state (r_state),
        .o_state (n_state)
    );

    // result scaling; products never exceed the field widths
    assign bus_prod  = BUS_PROD_W'(r_s2_bus) * BUS_PROD_W'(r_cfg.volt_scale);
    assign temp_prod = TEMP_PROD_W'(r_s2_temp) * TEMP_PROD_W'(TEMP_GAIN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ov_limit   <= RST_OV_LIMIT;
            r_cfg.uv_limit   <= RST_UV_LIMIT;
            r_cfg.oh_limit   <= RST_OH_LIMIT;
            r_cfg.oh_release <= RST_OH_RELEASE;
            r_cfg.volt_scale <= RST_VOLT_SCALE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_OV_LIMIT:   r_cfg.ov_limit   <= i_cfg_wdata[AVG_W-1:0];
                REG_UV_LIMIT:   r_cfg.uv_limit   <= i_cfg_wdata[AVG_W-1:0];
                REG_OH_LIMIT:   r_cfg.oh_limit   <= i_cfg_wdata[AVG_W-1:0];
                REG_OH_RELEASE: r_cfg.oh_release <= i_cfg_wdata[AVG_W-1:0];
                REG_VOLT_SCALE: r_cfg.volt_scale <= i_cfg_wdata[SCALE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_state.bus_avg  <= RST_BUS_AVG;
            r_state.temp_avg <= '0;
            r_state.flags    <= '0;
        end else begin
            if (s_axis_tready) begin
                r_v1 <= s_axis_tvalid;
            end
            if (w_ld2) begin
                r_v2 <= r_v1;
                if (r_v1) begin
                    r_state <= n_state;
                end
            end
            if (w_ld3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_item <= n_item;
        end
        if (w_ld2 && r_v1) begin
            r_s2_flags <= n_state.flags;
            r_s2_bus   <= n_state.bus_avg;
            r_s2_temp  <= n_state.temp_avg;
        end
        if (w_ld3 && r_v2) begin
            r_flags     <= r_s2_flags;
            r_all_clear <= (r_s2_flags == '0);
            r_bus_state <= bus_class(r_s2_bus, r_cfg.ov_limit, r_cfg.uv_limit);
            r_volts     <= bus_prod[FRAC_W +: VOLTS_W];
            r_celsius   <= temp_prod[FRAC_W +: CELS_W] + TEMP_OFFSET;
        end
    end

    assign m_axis_tvalid = r_v3;
    assign m_axis_tdata  = {7'd0, r_celsius, r_volts, r_bus_state, r_all_clear, r_flags};

    // the fault latch moves only when a word enters the update stage
    a_flags_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_ld2 && r_v1) |=> $stable(r_state.flags))
        else $error("fault latch changed without a word");

    // a delivered result reports the latch left by the last word
    a_flags_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && w_ld3 && !(w_ld2 && r_v1)) |=> (r_flags == r_state.flags))
        else $error("reported flags differ from latch");

    // bus state never holds the unused code, and celsius includes its offset
    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[8:7] != 2'd3) && (m_axis_tdata[32:25] >= TEMP_OFFSET))
        else $error("result field out of range");

endmodule

>>> sim/tb_power_stage_fault_monitor_top.sv
// tb_power_stage_fault_monitor_top: self-checking bench for the fault monitor top level,
// predicts every result word in order and compares it field by field with the stream output
// depends on psfm_pkg and power_stage_fault_monitor_top
`timescale 1ns / 1ps

module tb_power_stage_fault_monitor_top;

    import psfm_pkg::*;

    localparam logic [OP_W-1:0]      OP_SPARE_FIRST   = 3'd5;
    localparam logic [OP_W-1:0]      OP_SPARE_LAST    = 3'd7;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST   = 3'd7;
    localparam logic [AVG_W-1:0]     AVG_MAX          = 15'h7FFF;
    localparam logic [CFG_DATA_W-1:0] DATA_MAX        = 16'hFFFF;
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES   = 150;
    localparam int DRAIN_LIMIT   = 2000;
    localparam int PHASES        = 10;
    localparam int PHASE_WORDS   = 62;
    localparam int TIMEOUT_NS    = 500_000;

    typedef struct packed {
        logic [FLAG_W-1:0]  flags;
        logic               all_clear;
        logic [1:0]         bus_state;
        logic [VOLTS_W-1:0] volts;
        logic [CELS_W-1:0]  celsius;
    } t_monitor_result;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [39:0]           s_axis_tdata  = '0;
    logic [OP_W-1:0]       s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [39:0]           m_axis_tdata;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata   = '0;

    // predicted monitor state and register copies
    logic [AVG_W-1:0]   mon_bus_avg;
    logic [AVG_W-1:0]   mon_temp_avg;
    logic [FLAG_W-1:0]  mon_flags;
    logic [AVG_W-1:0]   lim_ov;
    logic [AVG_W-1:0]   lim_uv;
    logic [AVG_W-1:0]   lim_hot;
    logic [AVG_W-1:0]   lim_cool;
    logic [SCALE_W-1:0] volt_scale;

    t_monitor_result expected_q[$];

    bit          src_idle_en  = 1'b1;
    bit          sink_idle_en = 1'b1;
    bit          hold_req     = 1'b0;
    logic        sink_hold    = 1'b0;
    int unsigned sink_gap     = 0;

    int unsigned mismatches   = 0;
    int unsigned results_seen = 0;
    int unsigned words_sent   = 0;
    int unsigned reg_writes   = 0;
    int unsigned hot_words    = 0;
    int unsigned under_words  = 0;
    int unsigned spare_words  = 0;
    int unsigned op_seen [8];

    power_stage_fault_monitor_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        // [14:0] bus_sample, [29:15] temp_sample, [30] break_pin_high, [33:31] fault_kind
        .s_axis_tdata  (s_axis_tdata),
        // [2:0] operation
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // [5:0] fault_flags, [6] all_clear, [8:7] bus_state, [24:9] bus_volts,
        // [32:25] temp_celsius
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("power_stage_fault_monitor_top: mismatch");
        $finish;
    end

    // ---------------------------------------------------------------- prediction

    function automatic logic [AVG_W-1:0] ema_step(input logic [AVG_W-1:0] avg,
                                                  input logic [AVG_W-1:0] sample,
                                                  input int shift);
        logic [31:0] acc;
        acc = ((32'd1 << shift) - 32'd1) * 32'(avg) + 32'(sample);
        return AVG_W'(acc >> shift);
    endfunction

    function automatic t_bus_state bus_level();
        t_bus_state st;
        if (mon_bus_avg > lim_ov) begin
            st = BUS_OVER;
        end else if (mon_bus_avg < lim_uv) begin
            st = BUS_UNDER;
        end else begin
            st = BUS_OK;
        end
        return st;
    endfunction

    // advances the temperature average, then applies the hysteresis rule
    function automatic logic temp_step_hot(input logic [AVG_W-1:0] sample);
        logic hot;
        mon_temp_avg = ema_step(mon_temp_avg, sample, TEMP_AVG_SHIFT);
        if (mon_temp_avg >= lim_hot) begin
            hot = 1'b1;
        end else if (mon_temp_avg >= lim_cool) begin
            hot = mon_flags[FLAG_OVERHEAT];
        end else begin
            hot = 1'b0;
        end
        return hot;
    endfunction

    function automatic t_monitor_result monitor_step(input t_item it);
        t_monitor_result r;
        logic [AVG_W:0]  mid_sum;
        logic [31:0]     prod;
        case (it.op)
            OP_INIT: begin
                mid_sum      = {1'b0, lim_ov} + {1'b0, lim_uv};
                mon_bus_avg  = mid_sum[AVG_W:1];
                mon_temp_avg = '0;
            end
            OP_BUS_SAMPLE: begin
                mon_bus_avg = ema_step(mon_bus_avg, it.bus_sample, BUS_AVG_SHIFT);
            end
            OP_CHECK: begin
                if (temp_step_hot(it.temp_sample)) begin
                    mon_flags[FLAG_OVERHEAT] = 1'b1;
                end
                if (bus_level() == BUS_UNDER) begin
                    mon_flags[FLAG_UNDERVOLT] = 1'b1;
                end
            end
            OP_CLEAR: begin
                if (mon_flags[FLAG_OVERHEAT]) begin
                    if (!temp_step_hot(it.temp_sample)) begin
                        mon_flags[FLAG_OVERHEAT] = 1'b0;
                    end
                end
                if (bus_level() == BUS_OK) begin
                    mon_flags[FLAG_OVERVOLT]  = 1'b0;
                    mon_flags[FLAG_UNDERVOLT] = 1'b0;
                end
                if (it.break_pin_high) begin
                    mon_flags[FLAG_OVERCURRENT] = 1'b0;
                end
                mon_flags[FLAG_SPEEDFB] = 1'b0;
                mon_flags[FLAG_STARTUP] = 1'b0;
            end
            OP_SET_FAULT: begin
                if (it.fault_kind <= KIND_W'(FLAG_OVERVOLT)) begin
                    mon_flags[it.fault_kind] = 1'b1;
                end
            end
            default: begin
            end
        endcase
        r.flags     = mon_flags;
        r.all_clear = (mon_flags == '0);
        r.bus_state = bus_level();
        prod        = 32'(mon_bus_avg) * 32'(volt_scale);
        prod        = prod >> FRAC_W;
        r.volts     = (prod > 32'hFFFF) ? 16'hFFFF : prod[VOLTS_W-1:0];
        prod        = 32'(mon_temp_avg) * 32'(TEMP_GAIN);
        r.celsius   = CELS_W'((prod >> FRAC_W) + 32'(TEMP_OFFSET));
        return r;
    endfunction

    // ---------------------------------------------------------------- drivers

    task automatic send_word(input logic [OP_W-1:0] op, input logic [AVG_W-1:0] bs,
                             input logic [AVG_W-1:0] ts, input logic brk,
                             input logic [KIND_W-1:0] kind);
        t_item           it;
        t_monitor_result r;
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        it = {op, bs, ts, brk, kind};
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, kind, brk, ts, bs};
        s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        r = monitor_step(it);
        expected_q.push_back(r);
        words_sent++;
        op_seen[op]++;
        if (op >= OP_SPARE_FIRST) spare_words++;
        if (r.flags[FLAG_OVERHEAT]) hot_words++;
        if (r.flags[FLAG_UNDERVOLT]) under_words++;
    endtask

    function automatic logic [AVG_W-1:0] pick_sample();
        logic [AVG_W-1:0] v;
        case ($urandom_range(0, 7))
            0:       v = '0;
            1:       v = AVG_MAX;
            default: v = AVG_W'($urandom_range(0, AVG_MAX));
        endcase
        return v;
    endfunction

    task automatic send_random_word();
        int unsigned     pick;
        logic [OP_W-1:0] op;
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            op = OP_INIT;
        end else if (pick < 33) begin
            op = OP_BUS_SAMPLE;
        end else if (pick < 63) begin
            op = OP_CHECK;
        end else if (pick < 79) begin
            op = OP_CLEAR;
        end else if (pick < 94) begin
            op = OP_SET_FAULT;
        end else begin
            op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
        end
        send_word(op, pick_sample(), pick_sample(), 1'($urandom_range(0, 1)),
                  KIND_W'($urandom_range(0, (1 << KIND_W) - 1)));
    endtask

    // lowers valid and waits until the pipe has handed back every word
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            REG_OV_LIMIT:   lim_ov     = val[AVG_W-1:0];
            REG_UV_LIMIT:   lim_uv     = val[AVG_W-1:0];
            REG_OH_LIMIT:   lim_hot    = val[AVG_W-1:0];
            REG_OH_RELEASE: lim_cool   = val[AVG_W-1:0];
            REG_VOLT_SCALE: volt_scale = val;
            default: begin
            end
        endcase
        reg_writes++;
    endtask

    function automatic logic [CFG_DATA_W-1:0] clamp15(input int v);
        logic [CFG_DATA_W-1:0] c;
        if (v < 0) begin
            c = '0;
        end else if (v > int'(AVG_MAX)) begin
            c = CFG_DATA_W'(AVG_MAX);
        end else begin
            c = CFG_DATA_W'(v);
        end
        return c;
    endfunction

    // ---------------------------------------------------------------- result side

    always @(posedge i_clk) begin
        if (sink_gap == 0 && sink_idle_en && $urandom_range(0, 5) == 0) begin
            sink_gap = $urandom_range(1, 5);
        end
        if (sink_gap > 0) begin
            sink_gap--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !sink_hold;
        end
    end

    // long receiver hold-off, counted here
    initial begin
        wait (hold_req);
        @(posedge i_clk);
        sink_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        sink_hold <= 1'b0;
    end

    always @(posedge i_clk) begin : check_result
        t_monitor_result got;
        t_monitor_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.flags     = m_axis_tdata[5:0];
            got.all_clear = m_axis_tdata[6];
            got.bus_state = m_axis_tdata[8:7];
            got.volts     = m_axis_tdata[24:9];
            got.celsius   = m_axis_tdata[32:25];
            results_seen++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: result word %h with nothing expected", $realtime,
                             m_axis_tdata);
                end
            end else begin
                want = expected_q.pop_front();
                if (got.flags !== want.flags || got.all_clear !== want.all_clear ||
                    got.bus_state !== want.bus_state || got.volts !== want.volts ||
                    got.celsius !== want.celsius) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: expected flags %h clr %b bus %0d volts %0d cel %0d",
                                 $realtime, want.flags, want.all_clear, want.bus_state,
                                 want.volts, want.celsius);
                        $display("%0t:      got flags %h clr %b bus %0d volts %0d cel %0d",
                                 $realtime, got.flags, got.all_clear, got.bus_state,
                                 got.volts, got.celsius);
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------- tests

    task automatic test_directed_ops();
        send_word(OP_CHECK, AVG_MAX, '0, 1'b0, '0);
        send_word(OP_BUS_SAMPLE, '0, AVG_MAX, 1'b1, '0);
        send_word(OP_BUS_SAMPLE, AVG_MAX, '0, 1'b0, '1);
        for (int k = 0; k < (1 << KIND_W); k++) begin
            send_word(OP_SET_FAULT, '0, '0, 1'b0, KIND_W'(k));
        end
        send_word(OP_CHECK, '0, AVG_MAX, 1'b0, '0);
        send_word(OP_CLEAR, AVG_MAX, '0, 1'b0, '0);
        send_word(OP_CLEAR, '0, AVG_MAX, 1'b1, '1);
        for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++) begin
            send_word(OP_W'(op), AVG_MAX, AVG_MAX, 1'b1, '1);
        end
        send_word(OP_INIT, AVG_MAX, AVG_MAX, 1'b1, '1);
        send_word(OP_CHECK, '0, AVG_MAX, 1'b1, '1);
    endtask

    task automatic test_register_extremes();
        // upper data bit ignored on narrow limits, bus below both limits
        settle();
        write_reg(REG_OV_LIMIT, DATA_MAX);
        write_reg(REG_UV_LIMIT, DATA_MAX);
        write_reg(REG_OH_LIMIT, '0);
        write_reg(REG_OH_RELEASE, DATA_MAX);
        write_reg(REG_VOLT_SCALE, DATA_MAX);
        for (int k = REG_SPARE_FIRST; k <= REG_SPARE_LAST; k++) begin
            write_reg(CFG_IDX_W'(k), CFG_DATA_W'($urandom_range(0, DATA_MAX)));
        end
        i_cfg_we <= 1'b0;
        send_word(OP_CHECK, '0, '0, 1'b0, '0);
        send_word(OP_SET_FAULT, '0, '0, 1'b0, KIND_W'(FLAG_OVERVOLT));
        send_word(OP_SET_FAULT, '0, '0, 1'b0, KIND_W'(FLAG_OVERCURRENT));
        send_word(OP_CLEAR, '0, '0, 1'b1, '0);
        send_word(OP_BUS_SAMPLE, AVG_MAX, '0, 1'b0, '0);
        send_word(OP_BUS_SAMPLE, AVG_MAX, '0, 1'b0, '0);
        send_word(OP_INIT, '0, '0, 1'b0, '0);

        // overlapping voltage limits, over voltage wins; reversed hysteresis
        settle();
        write_reg(REG_OV_LIMIT, '0);
        write_reg(REG_UV_LIMIT, CFG_DATA_W'(AVG_MAX));
        write_reg(REG_OH_LIMIT, CFG_DATA_W'(AVG_MAX));
        write_reg(REG_OH_RELEASE, '0);
        write_reg(REG_VOLT_SCALE, '0);
        i_cfg_we <= 1'b0;
        send_word(OP_CHECK, '0, AVG_MAX, 1'b0, '0);
        send_word(OP_CLEAR, '0, AVG_MAX, 1'b0, '0);
        send_word(OP_BUS_SAMPLE, '0, '0, 1'b0, '0);
        send_word(OP_SET_FAULT, '0, '0, 1'b0, KIND_W'(FLAG_UNDERVOLT));
        send_word(OP_CLEAR, '0, '0, 1'b1, '0);
        send_word(OP_INIT, '0, '0, 1'b0, '0);

        settle();
        write_reg(REG_OV_LIMIT, CFG_DATA_W'(RST_OV_LIMIT));
        write_reg(REG_UV_LIMIT, CFG_DATA_W'(RST_UV_LIMIT));
        write_reg(REG_OH_LIMIT, CFG_DATA_W'(RST_OH_LIMIT));
        write_reg(REG_OH_RELEASE, CFG_DATA_W'(RST_OH_RELEASE));
        write_reg(REG_VOLT_SCALE, RST_VOLT_SCALE);
        i_cfg_we <= 1'b0;
        send_word(OP_INIT, '0, '0, 1'b0, '0);
        send_word(OP_CLEAR, '0, '0, 1'b1, '0);
    endtask

    task automatic test_backpressure();
        src_idle_en = 1'b0;
        hold_req    = 1'b1;
        repeat (40) send_random_word();
        src_idle_en = 1'b1;
    endtask

    // limits placed around the current averages so both sides of each threshold get hit
    task automatic test_random_phases();
        int bump;
        for (int p = 0; p < PHASES; p++) begin
            settle();
            bump = $urandom_range(0, 3000);
            if ($urandom_range(0, 3) == 0) begin
                write_reg(REG_OV_LIMIT, CFG_DATA_W'($urandom_range(0, DATA_MAX)));
                write_reg(REG_UV_LIMIT, CFG_DATA_W'($urandom_range(0, DATA_MAX)));
            end else begin
                write_reg(REG_OV_LIMIT, clamp15(int'(mon_bus_avg) + bump));
                bump = $urandom_range(0, 3000);
                write_reg(REG_UV_LIMIT, clamp15(int'(mon_bus_avg) - bump));
            end
            bump = $urandom_range(0, 60);
            write_reg(REG_OH_LIMIT, clamp15(int'(mon_temp_avg) + bump));
            bump = $urandom_range(0, 60);
            if ($urandom_range(0, 4) == 0) begin
                write_reg(REG_OH_RELEASE, clamp15(int'(mon_temp_avg) + bump + 20));
            end else begin
                write_reg(REG_OH_RELEASE, clamp15(int'(mon_temp_avg) - bump));
            end
            case ($urandom_range(0, 3))
                0:       write_reg(REG_VOLT_SCALE, '0);
                1:       write_reg(REG_VOLT_SCALE, DATA_MAX);
                default: write_reg(REG_VOLT_SCALE, CFG_DATA_W'($urandom_range(0, DATA_MAX)));
            endcase
            i_cfg_we <= 1'b0;
            src_idle_en  = ($urandom_range(0, 3) != 0);
            sink_idle_en = ($urandom_range(0, 3) != 0);
            repeat (PHASE_WORDS) send_random_word();
        end
    endtask

    task automatic test_steady_stream();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        repeat (60) send_random_word();
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        int drain;
        foreach (op_seen[k]) op_seen[k] = 0;
        lim_ov       = RST_OV_LIMIT;
        lim_uv       = RST_UV_LIMIT;
        lim_hot      = RST_OH_LIMIT;
        lim_cool     = RST_OH_RELEASE;
        volt_scale   = RST_VOLT_SCALE;
        mon_bus_avg  = RST_BUS_AVG;
        mon_temp_avg = '0;
        mon_flags    = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_ops();
        test_register_extremes();
        test_backpressure();
        test_random_phases();
        test_steady_stream();

        s_axis_tvalid <= 1'b0;
        drain = 0;
        while (expected_q.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("sent %0d words: %0d init, %0d bus, %0d check, %0d clear, %0d set, %0d spare",
                 words_sent, op_seen[OP_INIT], op_seen[OP_BUS_SAMPLE], op_seen[OP_CHECK],
                 op_seen[OP_CLEAR], op_seen[OP_SET_FAULT], spare_words);
        $display("%0d results, %0d register writes, overheat held in %0d, undervolt in %0d",
                 results_seen, reg_writes, hot_words, under_words);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("power_stage_fault_monitor_top: match");
        end else begin
            $display("power_stage_fault_monitor_top: mismatch");
        end
        $finish;
    end

endmodule
